// ----- hw/rtl/mtps_pkg.sv -----
package mtps_pkg;

    // default sample width
    localparam int SAMPLE_BITS_DEF = 16;

    // setup register layout
    localparam int SETUP_BITS = 48;
    localparam int FRAC_BITS  = 16;
    localparam logic [FRAC_BITS-1:0] FRAC_ONE = 16'hFFFF;
    localparam logic [SETUP_BITS-1:0] SETUP_RESET = 48'h8000_FFFF_0000;

    // register indexes
    localparam int CFG_IDX_BITS = 2;
    localparam logic [CFG_IDX_BITS-1:0] REG_RED   = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_GREEN = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_BLUE  = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_MONO  = 2'd3;

    localparam int LANES = 3;

    // per channel outcome decided before the divide
    typedef enum logic [1:0] {
        CODE_NORM = 2'd0,
        CODE_ZERO = 2'd1,
        CODE_FULL = 2'd2
    } t_code;

endpackage

// ----- hw/rtl/mtps_div.sv -----
module mtps_div #(
    parameter int SAMPLE_BITS = mtps_pkg::SAMPLE_BITS_DEF,
    parameter int DW          = SAMPLE_BITS + 33
) (
    input  logic                   i_clk,
    input  logic [DW-1:0]          i_num,
    input  logic [DW-1:0]          i_den,
    output logic [SAMPLE_BITS-1:0] o_quo
);
    import mtps_pkg::*;

    localparam int S = SAMPLE_BITS;

    logic [DW-1:0] r_rem [0:S];
    logic [DW-1:0] r_den [0:S];
    logic [DW-1:0] r_num [0:S];
    logic [S:0]    r_q   [0:S];
    logic [S-1:0]  r_out;

    // integer part of num/den, num never above den
    always_ff @(posedge i_clk) begin
        r_den[0] <= i_den;
        r_num[0] <= i_num;
        if (i_num >= i_den) begin
            r_rem[0] <= i_num - i_den;
            r_q[0]   <= (S+1)'(1);
        end else begin
            r_rem[0] <= i_num;
            r_q[0]   <= '0;
        end
    end

    // one restoring step per stage
    for (genvar k = 1; k <= S; k++) begin : g_step
        logic [DW:0] t_sh;
        logic        t_ge;
        assign t_sh = {r_rem[k-1], 1'b0};
        assign t_ge = t_sh >= {1'b0, r_den[k-1]};
        always_ff @(posedge i_clk) begin
            r_den[k] <= r_den[k-1];
            r_num[k] <= r_num[k-1];
            r_q[k]   <= {r_q[k-1][S-1:0], t_ge};
            r_rem[k] <= t_ge ? DW'(t_sh - {1'b0, r_den[k-1]}) : DW'(t_sh);
        end
    end

    // num*2^S to num*(2^S-1) correction
    always_ff @(posedge i_clk) begin
        if (r_rem[S] < r_num[S] && r_q[S] != '0) begin
            r_out <= S'(r_q[S] - (S+1)'(1));
        end else begin
            r_out <= r_q[S][S-1:0];
        end
    end

    assign o_quo = r_out;

endmodule

// ----- hw/rtl/mtps_lane.sv -----
module mtps_lane #(
    parameter int SAMPLE_BITS = mtps_pkg::SAMPLE_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic [SAMPLE_BITS-1:0]          i_sample,
    input  logic [mtps_pkg::SETUP_BITS-1:0] i_setup,
    output logic [SAMPLE_BITS-1:0]          o_value
);
    import mtps_pkg::*;

    localparam int S  = SAMPLE_BITS;
    localparam int NW = S + 16;
    localparam int PW = NW + 16;
    localparam int DW = PW + 1;

    logic [15:0] c_blk, c_wht, c_mid, c_span;
    assign c_blk  = i_setup[15:0];
    assign c_wht  = i_setup[31:16];
    assign c_mid  = i_setup[47:32];
    assign c_span = c_wht - c_blk;

    // stage 1: scale sample and black point to a common base
    logic [NW-1:0] r_lhs, r_rhs, r_d1;
    logic [15:0]   r_m1;
    logic          r_empty;
    always_ff @(posedge i_clk) begin
        r_lhs   <= {i_sample, 16'b0} - {16'b0, i_sample};
        r_rhs   <= {c_blk, S'(0)} - {S'(0), c_blk};
        r_d1    <= {c_span, S'(0)} - {S'(0), c_span};
        r_m1    <= c_mid;
        r_empty <= c_wht <= c_blk;
    end

    // stage 2: rescaled numerator and range check
    logic [NW-1:0] r_n, r_d2;
    logic [15:0]   r_m2;
    t_code         r_code;
    logic [NW-1:0] n_n;
    assign n_n = r_lhs - r_rhs;
    always_ff @(posedge i_clk) begin
        r_n  <= n_n;
        r_d2 <= r_d1;
        r_m2 <= r_m1;
        if (r_empty || r_lhs <= r_rhs) begin
            r_code <= CODE_ZERO;
        end else if (n_n >= r_d1) begin
            r_code <= CODE_FULL;
        end else begin
            r_code <= CODE_NORM;
        end
    end

    // stage 3: transfer function products
    logic [PW-1:0] r_a, r_md, r_qn;
    logic [DW-1:0] r_mn2;
    logic [NW-1:0] r_n3, r_d3;
    always_ff @(posedge i_clk) begin
        r_a   <= PW'(FRAC_ONE - r_m2) * PW'(r_n);
        r_md  <= PW'(r_m2) * PW'(r_d2);
        r_qn  <= {r_n, 16'b0} - {16'b0, r_n};
        r_mn2 <= {PW'(r_m2) * PW'(r_n), 1'b0};
        r_n3  <= r_n;
        r_d3  <= r_d2;
    end

    // stage 4: denominator and clamped numerator
    logic [DW-1:0] c_p, c_pm, r_num, r_den;
    assign c_p  = DW'(r_md) + DW'(r_qn);
    assign c_pm = c_p - r_mn2;
    always_ff @(posedge i_clk) begin
        if (c_p <= r_mn2) begin
            r_num <= DW'(r_n3);
            r_den <= DW'(r_d3);
        end else begin
            r_den <= c_pm;
            r_num <= (DW'(r_a) > c_pm) ? c_pm : DW'(r_a);
        end
    end

    logic [S-1:0] c_quo;
    mtps_div #(.SAMPLE_BITS(S), .DW(DW)) u_div (
        .i_clk (i_clk),
        .i_num (r_num),
        .i_den (r_den),
        .o_quo (c_quo)
    );

    // outcome code follows the divider
    localparam int CD = S + 4;
    t_code r_cd [0:CD-1];
    always_ff @(posedge i_clk) begin
        r_cd[0] <= r_code;
    end
    for (genvar k = 1; k < CD; k++) begin : g_cd
        always_ff @(posedge i_clk) begin
            r_cd[k] <= r_cd[k-1];
        end
    end

    // final selection
    always_comb begin
        unique case (r_cd[CD-1])
            CODE_NORM: o_value = c_quo;
            CODE_ZERO: o_value = '0;
            CODE_FULL: o_value = '1;
            default:   o_value = '0;
        endcase
    end

endmodule

// ----- hw/rtl/midtone_transfer_pixel_stretch.sv -----
// channel   | ports                                   | handshake
// pixel in  | i_red_in i_green_in i_blue_in i_frame_end | i_start, o_busy
// pixel out | o_red_out o_green_out o_blue_out o_frame_last | o_done strobe
// config    | i_cfg_idx i_cfg_data                    | i_cfg_we
// one pixel per cycle, each result marked by o_done after its i_start has passed
// through the per lane divide pipeline, one restoring stage per quotient bit
// o_busy stays low: every lane stage advances each cycle
// synchronous active low reset clears the valid line and the mono flag and loads SETUP_RESET into the setup registers
// results cannot be stalled; o_done marks each one for a single cycle
module midtone_transfer_pixel_stretch #(
    parameter int SAMPLE_BITS = mtps_pkg::SAMPLE_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    output logic                              o_busy,
    input  logic [SAMPLE_BITS-1:0]            i_red_in,
    input  logic [SAMPLE_BITS-1:0]            i_green_in,
    input  logic [SAMPLE_BITS-1:0]            i_blue_in,
    input  logic                              i_frame_end,
    output logic                              o_done,
    output logic [SAMPLE_BITS-1:0]            o_red_out,
    output logic [SAMPLE_BITS-1:0]            o_green_out,
    output logic [SAMPLE_BITS-1:0]            o_blue_out,
    output logic                              o_frame_last,
    input  logic                              i_cfg_we,
    input  logic [mtps_pkg::CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [mtps_pkg::SETUP_BITS-1:0]   i_cfg_data
);
    import mtps_pkg::*;

    localparam int S   = SAMPLE_BITS;
    localparam int LAT = S + 7;

    // configuration registers
    logic [SETUP_BITS-1:0] r_setup [0:LANES-1];
    logic                  r_mono;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_setup[0] <= SETUP_RESET;
            r_setup[1] <= SETUP_RESET;
            r_setup[2] <= SETUP_RESET;
            r_mono     <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_RED:   r_setup[0] <= i_cfg_data;
                REG_GREEN: r_setup[1] <= i_cfg_data;
                REG_BLUE:  r_setup[2] <= i_cfg_data;
                REG_MONO:  r_mono     <= i_cfg_data[0];
                default:   r_mono     <= r_mono;
            endcase
        end
    end

    assign o_busy = 1'b0;

    // channel lanes
    logic [S-1:0] c_smp [0:LANES-1];
    logic [S-1:0] c_val [0:LANES-1];
    assign c_smp[0] = i_red_in;
    assign c_smp[1] = i_green_in;
    assign c_smp[2] = i_blue_in;

    for (genvar k = 0; k < LANES; k++) begin : g_lane
        mtps_lane #(.SAMPLE_BITS(S)) u_lane (
            .i_clk    (i_clk),
            .i_sample (c_smp[k]),
            .i_setup  (r_setup[k]),
            .o_value  (c_val[k])
        );
    end

    // item valid and frame marker line
    logic [LAT-1:0] r_vld;
    logic [LAT-1:0] r_frm;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], i_start};
        end
        r_frm <= {r_frm[LAT-2:0], i_frame_end};
    end

    // merge lanes into the result
    logic [S-1:0] r_red, r_grn, r_blu;
    always_ff @(posedge i_clk) begin
        r_red <= c_val[0];
        r_grn <= r_mono ? '0 : c_val[1];
        r_blu <= r_mono ? '0 : c_val[2];
    end

    assign o_done       = r_vld[LAT-1];
    assign o_frame_last = r_frm[LAT-1];
    assign o_red_out    = r_red;
    assign o_green_out  = r_grn;
    assign o_blue_out   = r_blu;

endmodule
